// File: src/lru_replacement_tracker_defines.svh
// ----------------------------------------------------------------------------
// lru_replacement_tracker_defines.svh
// Assertion macros shared by the LRU replacement tracker.
// ----------------------------------------------------------------------------
`ifndef LRU_REPLACEMENT_TRACKER_DEFINES_SVH
`define LRU_REPLACEMENT_TRACKER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define LRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lrt_pkg.sv
// ----------------------------------------------------------------------------
// lrt_pkg
// Types and codes shared by the LRU replacement tracker modules.
// ----------------------------------------------------------------------------
package lrt_pkg;

   // Default geometry.
   localparam int LRT_SLOTS     = 16;
   localparam int LRT_PAGE_BITS = 32;

   // Fixed width of the page fields on the ports.
   localparam int LRT_PAGE_W = 32;

   // Access kinds.
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_HIT    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNTRACKED = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_DUPLICATE = 2'd3;

   // One request word.
   typedef struct packed {
      logic [1:0]            kind;
      logic [LRT_PAGE_W-1:0] page;
   } lrt_req_type;

   // One response word.
   typedef struct packed {
      logic [1:0]            status;
      logic                  stale_valid;
      logic [LRT_PAGE_W-1:0] stale_page;
   } lrt_rsp_type;

   // Handshake between the output stage and the engine.
   typedef struct packed {
      logic idle;
      logic done;
   } lrt_eng_status_type;

endpackage

// File: src/lrt_page_mem.sv
// ----------------------------------------------------------------------------
// lrt_page_mem
// Page store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrt_page_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/lrt_engine.sv
// ----------------------------------------------------------------------------
// lrt_engine
// Sequencer that walks the slots: a search pass that finds the page and the
// first free slot, an update pass that moves the recency ranks one slot per
// cycle and finds the new least recent slot, and a fetch of its page.
// ----------------------------------------------------------------------------
module lrt_engine #(
   parameter int SLOTS     = 16,
   parameter int PAGE_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  lrt_pkg::lrt_req_type       req_word,
   input  logic                       out_ready,
   output lrt_pkg::lrt_eng_status_type eng_status,
   output lrt_pkg::lrt_rsp_type       rsp_word
);

   import lrt_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int SCAN_W = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_UPDATE,
      S_FETCH,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [SCAN_W-1:0]    idx_ff, idx_in;
   logic [1:0]           kind_ff, kind_in;
   logic [PAGE_BITS-1:0] key_ff, key_in;
   logic                 match_ff, match_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]     match_rank_ff, match_rank_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 stale_ff, stale_in;
   logic [IDX_W-1:0]     stale_idx_ff, stale_idx_in;
   logic                 used_ff [SLOTS];
   logic                 used_in [SLOTS];
   logic [IDX_W-1:0]     rank_ff [SLOTS];
   logic [IDX_W-1:0]     rank_in [SLOTS];

   logic [IDX_W-1:0]     slot_idx;
   logic [IDX_W-1:0]     cmp_idx;
   logic                 slot_used;
   logic [IDX_W-1:0]     slot_rank;
   logic                 new_used;
   logic [IDX_W-1:0]     new_rank;
   logic [CNT_W-1:0]     new_count;
   logic                 ins_ok, hit_ok, rem_ok;
   logic [1:0]           status;
   logic [IDX_W-1:0]     rd_addr;
   logic [PAGE_BITS-1:0] rd_data;
   logic                 wr_en;

   // The search pass compares the read data in the cycle after its address.
   assign slot_idx  = idx_ff[IDX_W-1:0];
   assign cmp_idx   = IDX_W'(idx_ff - SCAN_W'(1));
   assign slot_used = used_ff[(state_ff == S_SEARCH) ? cmp_idx : slot_idx];
   assign slot_rank = rank_ff[(state_ff == S_SEARCH) ? cmp_idx : slot_idx];

   // Outcome of the access, from the flags left by the search pass.
   always_comb begin
      ins_ok = 1'b0;
      hit_ok = 1'b0;
      rem_ok = 1'b0;
      status = ST_OK;
      unique case (kind_ff)
         KIND_INSERT: begin
            if (match_ff) begin
               status = ST_DUPLICATE;
            end else if (!free_ff) begin
               status = ST_FULL;
            end else begin
               ins_ok = 1'b1;
            end
         end
         KIND_HIT: begin
            if (match_ff) begin
               hit_ok = 1'b1;
            end else begin
               status = ST_UNTRACKED;
            end
         end
         KIND_REMOVE: begin
            if (match_ff) begin
               rem_ok = 1'b1;
            end else begin
               status = ST_UNTRACKED;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // Occupancy after the access.
   always_comb begin
      new_count = count_ff;
      if (ins_ok) begin
         new_count = count_ff + CNT_W'(1);
      end else if (rem_ok) begin
         new_count = count_ff - CNT_W'(1);
      end
   end

   // Shared rank update unit, applied to one slot per cycle.
   always_comb begin
      new_used = slot_used;
      new_rank = slot_rank;
      if (ins_ok) begin
         if (slot_idx == free_idx_ff) begin
            new_used = 1'b1;
            new_rank = '0;
         end else if (slot_used) begin
            new_rank = slot_rank + IDX_W'(1);
         end
      end else if (hit_ok) begin
         if (slot_idx == match_idx_ff) begin
            new_rank = '0;
         end else if (slot_used && (slot_rank < match_rank_ff)) begin
            new_rank = slot_rank + IDX_W'(1);
         end
      end else if (rem_ok) begin
         if (slot_idx == match_idx_ff) begin
            new_used = 1'b0;
            new_rank = '0;
         end else if (slot_used && (slot_rank > match_rank_ff)) begin
            new_rank = slot_rank - IDX_W'(1);
         end
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_rank_in = match_rank_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      stale_in      = stale_ff;
      stale_idx_in  = stale_idx_ff;
      used_in       = used_ff;
      rank_in       = rank_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SEARCH;
               idx_in   = '0;
               kind_in  = req_word.kind;
               key_in   = PAGE_BITS'(req_word.page);
               match_in = 1'b0;
               free_in  = 1'b0;
            end
         end
         S_SEARCH: begin
            // Look at the slot whose page was read last cycle.
            if (idx_ff != '0) begin
               if (slot_used && !match_ff && (rd_data == key_ff)) begin
                  match_in      = 1'b1;
                  match_idx_in  = cmp_idx;
                  match_rank_in = slot_rank;
               end
               if (!slot_used && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx;
               end
            end
            if (idx_ff == SCAN_W'(SLOTS)) begin
               state_in = S_UPDATE;
               idx_in   = '0;
               stale_in = 1'b0;
            end else begin
               idx_in = idx_ff + SCAN_W'(1);
            end
         end
         S_UPDATE: begin
            used_in[slot_idx] = new_used;
            rank_in[slot_idx] = new_rank;
            // The least recent slot holds rank count-1.
            if (new_used && !stale_ff && (CNT_W'(new_rank) == new_count - CNT_W'(1))) begin
               stale_in     = 1'b1;
               stale_idx_in = slot_idx;
            end
            if (idx_ff == SCAN_W'(SLOTS - 1)) begin
               state_in = S_FETCH;
               count_in = new_count;
            end else begin
               idx_in = idx_ff + SCAN_W'(1);
            end
         end
         S_FETCH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i] <= 1'b0;
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         used_ff  <= used_in;
         rank_ff  <= rank_in;
      end
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      match_ff      <= match_in;
      match_idx_ff  <= match_idx_in;
      match_rank_ff <= match_rank_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      stale_ff      <= stale_in;
      stale_idx_ff  <= stale_idx_in;
   end

   // The new page is written once, at the start of the update pass.
   assign wr_en = (state_ff == S_UPDATE) && (idx_ff == '0) && ins_ok;

   // Walk the store during search, then hold on the least recent slot.
   assign rd_addr = ((state_ff == S_SEARCH) && (idx_ff != SCAN_W'(SLOTS))) ? slot_idx
                                                                          : stale_idx_ff;

   lrt_page_mem #(
      .DEPTH (SLOTS),
      .WIDTH (PAGE_BITS)
   ) u_page_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result word, valid in the done state.
   assign eng_status.idle      = (state_ff == S_IDLE);
   assign eng_status.done      = (state_ff == S_DONE);
   assign rsp_word.status      = status;
   assign rsp_word.stale_valid = stale_ff;
   assign rsp_word.stale_page  = stale_ff ? LRT_PAGE_W'(rd_data) : '0;

endmodule

// File: src/lru_replacement_tracker.sv
// ----------------------------------------------------------------------------
// lru_replacement_tracker
// Exact LRU tracker over a fixed number of slots with a valid/stall request
// channel and a registered response channel.
// ----------------------------------------------------------------------------
// Usage:
//   Each request word carries a kind (insert, hit, remove) and a page. Every
//   request produces exactly one response word with a status, a flag that
//   says whether any page is tracked, and the least recently used page.
//   A request is taken when req_valid is high and req_stall is low; a
//   response leaves when rsp_valid is high and rsp_stall is low.
//   The engine walks the slot store twice, one slot per cycle: a search
//   pass over every slot and a rank update pass, followed by a fetch of
//   the stale page. The response is registered after the fetch, and a
//   new request is taken only once the engine has handed its previous
//   result to the output register and is idle again.
//   The slot-at-a-time walks, through the one read port of the page store
//   and the one shared rank update unit, set the request rate.
//   req_stall is high while an item is in progress. A finished response
//   waits in the output register while the next request is processed; if
//   the receiver still stalls when the next result is ready, the engine
//   holds it and stalls further requests.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_replacement_tracker #(
   parameter int SLOTS     = lrt_pkg::LRT_SLOTS,
   parameter int PAGE_BITS = lrt_pkg::LRT_PAGE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lrt_pkg::lrt_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lrt_pkg::lrt_rsp_type rsp_word
);

   import lrt_pkg::*;

   `include "lru_replacement_tracker_defines.svh"

   lrt_eng_status_type eng_status;
   lrt_rsp_type        eng_rsp;
   logic               out_ready;
   logic               start;
   logic               rsp_valid_ff, rsp_valid_in;
   lrt_rsp_type        rsp_word_ff, rsp_word_in;

   // Requests are taken only by an idle engine.
   assign req_stall = !eng_status.idle;
   assign start     = req_valid && !req_stall;

   // The output register is free when empty or being drained.
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   lrt_engine #(
      .SLOTS     (SLOTS),
      .PAGE_BITS (PAGE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .out_ready  (out_ready),
      .eng_status (eng_status),
      .rsp_word   (eng_rsp)
   );

   // Output register next value.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_ready) begin
         rsp_valid_in = eng_status.done;
         if (eng_status.done) begin
            rsp_word_in = eng_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // A taken request keeps the engine busy on the next cycle.
   `LRT_ASSERT_NEXT(a_busy_after_accept, start, req_stall, "engine idle after accept")

   // A full table always has a least recent page to report.
   `LRT_ASSERT_NOW(a_full_has_stale, rsp_valid && (rsp_word.status == ST_FULL),
                   rsp_word.stale_valid, "full table without stale page")

   // With nothing tracked the stale page reads as zero.
   `LRT_ASSERT_NOW(a_empty_page_zero, rsp_valid && !rsp_word.stale_valid,
                   rsp_word.stale_page == '0, "stale page not zero on empty table")

   // The engine never finishes an item while idle.
   `LRT_ASSERT_NOW(a_done_not_idle, eng_status.done, !eng_status.idle,
                   "engine done and idle together")

endmodule

// File: test/lru_replacement_tracker_checker.sv
// ----------------------------------------------------------------------------
// lru_replacement_tracker_checker
// Watches both channels of the LRU replacement tracker and checks every
// response word against an independent model of the recency table. Each
// accepted request word updates the model and queues the response that it
// should produce. Each accepted response word is compared, field by field,
// with the oldest queued one.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  lrt_pkg::lrt_req_type req_word,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lrt_pkg::lrt_rsp_type rsp_word,
   output int                   fail_count,
   output int                   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import lrt_pkg::*;

   localparam int RANK_W  = $clog2(LRT_SLOTS);
   localparam int COUNT_W = $clog2(LRT_SLOTS + 1);

   // Model of the recency table: rank 0 is the most recent page.
   logic [LRT_PAGE_W-1:0] held_page [LRT_SLOTS];
   logic                  held_used [LRT_SLOTS];
   logic [RANK_W-1:0]     held_rank [LRT_SLOTS];
   logic [COUNT_W-1:0]    held_count;

   // Responses owed by the block, oldest first.
   lrt_rsp_type due_reports [$];

   // Applies one access to the table and returns the report it causes.
   function automatic lrt_rsp_type touch_and_report(input lrt_req_type w);
      int                found_at;
      int                free_at;
      logic [RANK_W-1:0] old_rank;
      lrt_rsp_type       report;
      found_at = -1;
      free_at  = -1;
      for (int i = 0; i < LRT_SLOTS; i++) begin
         if (held_used[i] && held_page[i] == w.page && found_at < 0) begin
            found_at = i;
         end
         if (!held_used[i] && free_at < 0) begin
            free_at = i;
         end
      end
      report = '0;
      report.status = ST_OK;
      case (w.kind)
         KIND_INSERT: begin
            if (found_at >= 0) begin
               report.status = ST_DUPLICATE;
            end else if (free_at < 0) begin
               report.status = ST_FULL;
            end else begin
               // Every tracked page ages by one; the new page is the most recent.
               for (int i = 0; i < LRT_SLOTS; i++) begin
                  if (held_used[i]) begin
                     held_rank[i] = held_rank[i] + 1'b1;
                  end
               end
               held_used[free_at] = 1'b1;
               held_page[free_at] = w.page;
               held_rank[free_at] = '0;
               held_count = held_count + 1'b1;
            end
         end
         KIND_HIT: begin
            if (found_at < 0) begin
               report.status = ST_UNTRACKED;
            end else begin
               // Pages more recent than the touched one age by one.
               old_rank = held_rank[found_at];
               for (int i = 0; i < LRT_SLOTS; i++) begin
                  if (held_used[i] && held_rank[i] < old_rank) begin
                     held_rank[i] = held_rank[i] + 1'b1;
                  end
               end
               held_rank[found_at] = '0;
            end
         end
         KIND_REMOVE: begin
            if (found_at < 0) begin
               report.status = ST_UNTRACKED;
            end else begin
               // Pages older than the removed one close the gap.
               old_rank = held_rank[found_at];
               for (int i = 0; i < LRT_SLOTS; i++) begin
                  if (held_used[i] && held_rank[i] > old_rank) begin
                     held_rank[i] = held_rank[i] - 1'b1;
                  end
               end
               held_used[found_at] = 1'b0;
               held_rank[found_at] = '0;
               held_count = held_count - 1'b1;
            end
         end
         default: begin
         end
      endcase
      // The least recently used page holds the highest rank in use.
      if (held_count != 0) begin
         for (int i = 0; i < LRT_SLOTS; i++) begin
            if (held_used[i] && !report.stale_valid &&
                COUNT_W'(held_rank[i]) == held_count - 1'b1) begin
               report.stale_valid = 1'b1;
               report.stale_page  = held_page[i];
            end
         end
      end
      return report;
   endfunction

   // Compare each accepted response, then record each accepted request.
   always @(posedge clock) begin : watch_words
      lrt_rsp_type want;
      if (reset) begin
         for (int i = 0; i < LRT_SLOTS; i++) begin
            held_page[i] = '0;
            held_used[i] = 1'b0;
            held_rank[i] = '0;
         end
         held_count = '0;
         due_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_reports.size() == 0) begin
               $display("%0t: response word with none due: status %0d valid %0b page %h",
                        $time, rsp_word.status, rsp_word.stale_valid, rsp_word.stale_page);
               fail_count++;
            end else begin
               want = due_reports.pop_front();
               if (rsp_word.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_word.status);
                  fail_count++;
               end
               if (rsp_word.stale_valid !== want.stale_valid) begin
                  $display("%0t: stale_valid mismatch, expected %0b, actual %0b",
                           $time, want.stale_valid, rsp_word.stale_valid);
                  fail_count++;
               end
               if (rsp_word.stale_page !== want.stale_page) begin
                  $display("%0t: stale_page mismatch, expected %h, actual %h",
                           $time, want.stale_page, rsp_word.stale_page);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            due_reports.push_back(touch_and_report(req_word));
         end
      end
      outstanding <= due_reports.size();
   end

endmodule

// File: test/tb_lru_replacement_tracker.sv
// ----------------------------------------------------------------------------
// tb_lru_replacement_tracker
// Stimulus and verdict for the LRU replacement tracker. A directed sequence
// fills, overflows and prunes the table, then random accesses over a small
// page pool run through phases of sender gaps and receiver stalls, including
// one long receiver hold-off. The checker module does all comparison.
// ----------------------------------------------------------------------------
module tb_lru_replacement_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import lrt_pkg::*;

   localparam int          PHASE_WORDS  = 100;
   localparam int          POOL_SIZE    = 20;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          SETTLE_WAIT  = 2 * LRT_SLOTS + 10;
   localparam int          LIMIT_CYCLES = 400000;
   localparam logic [1:0]  KIND_UNUSED  = 2'd3;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   lrt_req_type req_word  = '0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   lrt_rsp_type rsp_word;
   int          fail_count;
   int          outstanding;

   // Idling knobs, written by the stimulus process only.
   int idle_pct   = 0;
   int stall_pct  = 0;
   int hold_gen   = 0;

   // Cycle count for the watchdog.
   int cycles     = 0;

   logic [LRT_PAGE_W-1:0] page_pool [POOL_SIZE];

   always #6 clock = ~clock;

   lru_replacement_tracker uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   lru_replacement_tracker_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d responses due", cycles, outstanding);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin : receiver
      int hold_taken;
      hold_taken = 0;
      forever begin
         @(posedge clock);
         if (hold_gen != hold_taken) begin
            hold_taken = hold_gen;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
      end
   end

   // Offers one word, with a random gap first, and returns once it is taken.
   task automatic send_word(input logic [1:0] kind, input logic [LRT_PAGE_W-1:0] page);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{kind: kind, page: page};
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Stops offering and waits until every due response has been taken.
   task automatic drain_all();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (outstanding != 0);
   endtask

   // Random accesses over the page pool; the insert share shifts every
   // twenty words so that the table both fills up and empties out.
   task automatic run_random(input int goal);
      int                    sent;
      int                    insert_pct;
      int                    pick;
      logic [1:0]            kind;
      logic [LRT_PAGE_W-1:0] page;
      sent       = 0;
      insert_pct = 40;
      while (sent < goal) begin
         if (sent % 20 == 0) begin
            insert_pct = $urandom_range(70, 15);
         end
         pick = $urandom_range(99);
         if (pick < insert_pct) begin
            kind = KIND_INSERT;
         end else if (pick < insert_pct + (100 - insert_pct) * 3 / 5) begin
            kind = KIND_HIT;
         end else if (pick < 96) begin
            kind = KIND_REMOVE;
         end else begin
            kind = KIND_UNUSED;
         end
         // Mostly pool pages so that hits, removes and duplicates land.
         if (kind == KIND_INSERT || $urandom_range(99) < 85) begin
            page = page_pool[$urandom_range(POOL_SIZE - 1)];
         end else begin
            page = $urandom;
         end
         send_word(kind, page);
         if (kind != KIND_UNUSED) begin
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         page_pool[i] = $urandom;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table cases, fill to full, overflow, duplicate,
      // touch of the oldest page, removal of the oldest and of a middle page.
      send_word(KIND_HIT, page_pool[0]);
      send_word(KIND_REMOVE, page_pool[1]);
      send_word(KIND_UNUSED, page_pool[2]);
      for (int i = 0; i < LRT_SLOTS; i++) begin
         send_word(KIND_INSERT, page_pool[i]);
      end
      send_word(KIND_INSERT, page_pool[LRT_SLOTS]);
      send_word(KIND_INSERT, page_pool[5]);
      send_word(KIND_HIT, page_pool[0]);
      send_word(KIND_REMOVE, page_pool[1]);
      send_word(KIND_REMOVE, page_pool[7]);
      send_word(KIND_UNUSED, page_pool[3]);
      drain_all();

      // Random phases: no idling with a long receiver hold-off, sender gaps,
      // receiver stalls, and light idling on both sides.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
               hold_gen  = hold_gen + 1;
            end
            1: begin
               idle_pct  = 79;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 79;
            end
            default: begin
               idle_pct  = 9;
               stall_pct = 9;
            end
         endcase
         run_random(PHASE_WORDS);
         drain_all();
      end

      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
